>>> rtl/core/scl_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the sequential_char_list block
// no dependencies

package scl_pkg;

    localparam int unsigned ACTION_W   = 3;
    localparam int unsigned POSITION_W = 4;
    localparam int unsigned VALUE_W    = 8;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned FOUND_W    = 4;
    localparam int unsigned LENGTH_W   = 5;

    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 24;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND    = 3'd0,
        ACT_INSERT    = 3'd1,
        ACT_REMOVE    = 3'd2,
        ACT_OVERWRITE = 3'd3,
        ACT_READ      = 3'd4,
        ACT_SEARCH    = 3'd5
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_SHIFT_UP,
        FSM_SHIFT_DOWN,
        FSM_READ_WAIT,
        FSM_SEARCH,
        FSM_DONE
    } fsm_t;

endpackage

>>> rtl/core/scl_ram.sv
`timescale 1ns / 1ps
// generic single-clock ram, one write port and one registered read port
// no dependencies

module scl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/sequential_char_list.sv
`timescale 1ns / 1ps
// top level of the ordered byte list with shift insert and shift remove
// depends on scl_pkg and scl_ram

// An ordered list of up to CAPACITY bytes kept in one ram with a fill count.
// Each input transfer carries one action and yields one result transfer with
// status, read byte, found index and the length after the action. One action
// is worked at a time. Append, overwrite, rejected actions and unknown codes
// pass through the execute and done states before the result register; read
// adds a wait state for the registered ram read. Insert and remove move one
// entry per cycle through the single ram port pair, and search reads one
// entry per cycle. A finished result waits in the output register while the
// next action is taken in.

module sequential_char_list #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // action [2:0], position [6:3], value [14:7], zero [15]
    input  logic [scl_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // status [2:0], read_value [10:3], found_index [14:11], length [19:15], zero [23:20]
    output logic [scl_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready
);

    import scl_pkg::*;

    localparam int unsigned AW   = $clog2(CAPACITY);
    localparam int unsigned CW   = $clog2(CAPACITY + 1);
    localparam int unsigned CMPW = (CW > POSITION_W) ? CW : POSITION_W;
    localparam int unsigned LW   = (CW > LENGTH_W) ? CW : LENGTH_W;

    fsm_t                state_reg, state_next;
    action_t             act_reg, act_next;
    logic [CMPW-1:0]     pos_reg, pos_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CMPW-1:0]     ptr_reg, ptr_next;
    logic                pend_reg, pend_next;
    logic [AW-1:0]       pend_addr_reg, pend_addr_next;
    status_t             status_reg, status_next;
    logic [VALUE_W-1:0]  rd_reg, rd_next;
    logic [CMPW-1:0]     found_reg, found_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [VALUE_W-1:0]  ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [VALUE_W-1:0]  ram_rdata;

    logic [CMPW-1:0]     cnt_ext;
    logic [CMPW-1:0]     ptr_inc;
    logic [LW-1:0]       len_ext;
    logic                full;
    logic                accept;

    scl_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cnt_ext  = CMPW'(count_reg);
    assign ptr_inc  = ptr_reg + CMPW'(1);
    assign len_ext  = LW'(count_reg);
    assign full     = (count_reg == CW'(CAPACITY));
    assign s_tready = (state_reg == FSM_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg       <= act_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        ptr_reg       <= ptr_next;
        pend_addr_reg <= pend_addr_next;
        status_reg    <= status_next;
        rd_reg        <= rd_next;
        found_reg     <= found_next;
        m_data_reg    <= m_data_next;
    end

    always_comb begin
        state_next     = state_reg;
        act_next       = act_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        status_next    = status_reg;
        rd_next        = rd_reg;
        found_next     = found_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = val_reg;
        ram_raddr      = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    act_next   = action_t'(s_tdata[ACTION_W-1:0]);
                    pos_next   = CMPW'(s_tdata[ACTION_W +: POSITION_W]);
                    val_next   = s_tdata[ACTION_W+POSITION_W +: VALUE_W];
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                status_next = ST_OK;
                rd_next     = '0;
                found_next  = '0;
                pend_next   = 1'b0;
                state_next  = FSM_DONE;
                case (act_reg)
                    ACT_APPEND: begin
                        if (full) begin
                            status_next = ST_FULL;
                        end else begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[AW-1:0];
                            count_next = count_reg + CW'(1);
                        end
                    end
                    ACT_INSERT: begin
                        if (full) begin
                            status_next = ST_FULL;
                        end else if (pos_reg > cnt_ext) begin
                            status_next = ST_BADPOS;
                        end else begin
                            ptr_next   = cnt_ext;
                            state_next = FSM_SHIFT_UP;
                        end
                    end
                    ACT_REMOVE: begin
                        if (count_reg == '0) begin
                            status_next = ST_EMPTY;
                        end else if (pos_reg >= cnt_ext) begin
                            status_next = ST_BADPOS;
                        end else begin
                            ptr_next   = pos_reg;
                            state_next = FSM_SHIFT_DOWN;
                        end
                    end
                    ACT_OVERWRITE: begin
                        if (pos_reg >= cnt_ext) begin
                            status_next = ST_BADPOS;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = pos_reg[AW-1:0];
                        end
                    end
                    ACT_READ: begin
                        if (pos_reg >= cnt_ext) begin
                            status_next = ST_BADPOS;
                        end else begin
                            ram_raddr  = pos_reg[AW-1:0];
                            state_next = FSM_READ_WAIT;
                        end
                    end
                    ACT_SEARCH: begin
                        if (count_reg == '0) begin
                            status_next = ST_EMPTY;
                        end else begin
                            ptr_next   = '0;
                            state_next = FSM_SEARCH;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            FSM_SHIFT_UP: begin
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg;
                    ram_wdata = ram_rdata;
                end
                if (ptr_reg > pos_reg) begin
                    ram_raddr      = ptr_reg[AW-1:0] - AW'(1);
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg[AW-1:0];
                    ptr_next       = ptr_reg - CMPW'(1);
                end else if (pend_reg) begin
                    pend_next = 1'b0;
                end else begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_reg[AW-1:0];
                    ram_wdata  = val_reg;
                    count_next = count_reg + CW'(1);
                    state_next = FSM_DONE;
                end
            end
            FSM_SHIFT_DOWN: begin
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg;
                    ram_wdata = ram_rdata;
                end
                if (ptr_inc < cnt_ext) begin
                    ram_raddr      = ptr_inc[AW-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg[AW-1:0];
                    ptr_next       = ptr_inc;
                end else begin
                    pend_next  = 1'b0;
                    count_next = count_reg - CW'(1);
                    state_next = FSM_DONE;
                end
            end
            FSM_READ_WAIT: begin
                rd_next    = ram_rdata;
                state_next = FSM_DONE;
            end
            FSM_SEARCH: begin
                if (pend_reg && (ram_rdata == val_reg)) begin
                    status_next = ST_OK;
                    found_next  = CMPW'(pend_addr_reg);
                    pend_next   = 1'b0;
                    state_next  = FSM_DONE;
                end else if (ptr_reg >= cnt_ext) begin
                    status_next = ST_NOTFOUND;
                    pend_next   = 1'b0;
                    state_next  = FSM_DONE;
                end else begin
                    ram_raddr      = ptr_reg[AW-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg[AW-1:0];
                    ptr_next       = ptr_inc;
                end
            end
            FSM_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'b0, len_ext[LENGTH_W-1:0], found_reg[FOUND_W-1:0],
                                    rd_reg, status_reg};
                    state_next   = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

endmodule

>>> tb/scl_list_checker.sv
`timescale 1ns / 1ps
// checker for the sequential_char_list block: watches both stream channels,
// keeps its own copy of the byte list and compares every result transfer
// depends on scl_pkg

module scl_list_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [scl_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [scl_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    output int                             errors,
    output int                             pending,
    output int                             checked
);

    import scl_pkg::*;

    localparam int LIST_DEPTH = 16;

    typedef struct packed {
        status_t      status;
        logic [7:0]   rd;
        logic [3:0]   idx;
        logic [4:0]   len;
    } list_result_t;

    logic [7:0]   list_mem [0:LIST_DEPTH-1];
    logic [4:0]   list_len;
    list_result_t expected_results [$];

    function automatic list_result_t list_apply(input logic [2:0] act,
                                                input logic [3:0] pos,
                                                input logic [7:0] val);
        list_result_t r;
        int k;
        r.status = ST_OK;
        r.rd     = '0;
        r.idx    = '0;
        case (act)
            ACT_APPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_mem[list_len] = val;
                    list_len++;
                end
            end
            ACT_INSERT: begin
                if (list_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else if (pos > list_len) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (k = list_len; k > pos; k--)
                        list_mem[k] = list_mem[k-1];
                    list_mem[pos] = val;
                    list_len++;
                end
            end
            ACT_REMOVE: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (pos >= list_len) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (k = pos; k + 1 < list_len; k++)
                        list_mem[k] = list_mem[k+1];
                    list_len--;
                end
            end
            ACT_OVERWRITE: begin
                if (pos >= list_len)
                    r.status = ST_BADPOS;
                else
                    list_mem[pos] = val;
            end
            ACT_READ: begin
                if (pos >= list_len)
                    r.status = ST_BADPOS;
                else
                    r.rd = list_mem[pos];
            end
            ACT_SEARCH: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.status = ST_NOTFOUND;
                    for (k = 0; k < list_len && r.status != ST_OK; k++) begin
                        if (list_mem[k] == val) begin
                            r.status = ST_OK;
                            r.idx    = k[3:0];
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        r.len = list_len;
        return r;
    endfunction

    always @(posedge aclk) begin
        list_result_t exp_r;
        int           n_err;
        n_err = 0;
        if (!aresetn) begin
            list_len = '0;
            expected_results.delete();
            errors  <= 0;
            pending <= 0;
            checked <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no action outstanding: %h", m_tdata);
                    n_err++;
                end else begin
                    exp_r = expected_results.pop_front();
                    checked <= checked + 1;
                    if (m_tdata[2:0] !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, m_tdata[2:0]);
                        n_err++;
                    end
                    if (m_tdata[10:3] !== exp_r.rd) begin
                        $error("read_value: expected %0d, got %0d", exp_r.rd, m_tdata[10:3]);
                        n_err++;
                    end
                    if (m_tdata[14:11] !== exp_r.idx) begin
                        $error("found_index: expected %0d, got %0d", exp_r.idx,
                               m_tdata[14:11]);
                        n_err++;
                    end
                    if (m_tdata[19:15] !== exp_r.len) begin
                        $error("length: expected %0d, got %0d", exp_r.len, m_tdata[19:15]);
                        n_err++;
                    end
                end
            end
            errors <= errors + n_err;
            if (s_tvalid && s_tready)
                expected_results.push_back(list_apply(s_tdata[2:0], s_tdata[6:3],
                                                      s_tdata[14:7]));
            pending <= expected_results.size();
        end
    end

endmodule

>>> tb/sequential_char_list_tb.sv
`timescale 1ns / 1ps
// testbench top for sequential_char_list: clock, reset, action stimulus and
// result-side backpressure, with the verdict taken from scl_list_checker
// depends on scl_pkg, scl_list_checker and the sequential_char_list rtl

module sequential_char_list_tb;

    import scl_pkg::*;

    localparam logic [2:0] ACT_RSVD_LO = 3'd6;
    localparam logic [2:0] ACT_RSVD_HI = 3'd7;
    localparam int RANDOM_ITEMS = 1450;

    typedef enum int { PH_GROW, PH_SHRINK, PH_MIXED } phase_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;

    int     errors;
    int     pending;
    int     checked;
    int     stall_left = 0;
    bit     calm = 1'b0;
    int     n_directed = 0;
    int     n_random = 0;
    phase_t phase;

    always #6 aclk = ~aclk;

    sequential_char_list #(
        .CAPACITY (16)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    scl_list_checker i_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .errors   (errors),
        .pending  (pending),
        .checked  (checked)
    );

    // result-side backpressure
    always @(negedge aclk) begin
        int r;
        r = $urandom_range(0, 99);
        if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (calm || r < 65) begin
            m_tready <= 1'b1;
        end else if (r < 95) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 3);
        end else begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(8, 40);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_action(input logic [2:0] act, input logic [3:0] pos,
                               input logic [7:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = {1'b0, val, pos, act};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic directed_action(input logic [2:0] act, input logic [3:0] pos,
                                   input logic [7:0] val);
        send_action(act, pos, val);
        n_directed++;
    endtask

    function automatic logic [2:0] pick_action(input phase_t ph);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return ($urandom_range(0, 1) != 0) ? ACT_RSVD_HI : ACT_RSVD_LO;
        case (ph)
            PH_GROW: begin
                if (r < 45) return ACT_APPEND;
                if (r < 68) return ACT_INSERT;
                if (r < 76) return ACT_REMOVE;
                if (r < 84) return ACT_OVERWRITE;
                if (r < 92) return ACT_READ;
                return ACT_SEARCH;
            end
            PH_SHRINK: begin
                if (r < 50) return ACT_REMOVE;
                if (r < 58) return ACT_APPEND;
                if (r < 63) return ACT_INSERT;
                if (r < 72) return ACT_OVERWRITE;
                if (r < 86) return ACT_READ;
                return ACT_SEARCH;
            end
            default: begin
                if (r < 20) return ACT_APPEND;
                if (r < 36) return ACT_INSERT;
                if (r < 54) return ACT_REMOVE;
                if (r < 68) return ACT_OVERWRITE;
                if (r < 84) return ACT_READ;
                return ACT_SEARCH;
            end
        endcase
    endfunction

    initial begin
        int k;
        logic [2:0] act;
        logic [3:0] pos;
        logic [7:0] val;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty list corner cases
        directed_action(ACT_REMOVE, 4'd0, 8'h00);
        directed_action(ACT_SEARCH, 4'd0, 8'h00);
        directed_action(ACT_READ, 4'd0, 8'h00);
        directed_action(ACT_OVERWRITE, 4'd0, 8'hff);
        directed_action(ACT_INSERT, 4'd1, 8'h11);
        directed_action(ACT_INSERT, 4'd0, 8'h00);
        directed_action(ACT_RSVD_LO, 4'd15, 8'hff);
        directed_action(ACT_RSVD_HI, 4'd0, 8'h5a);
        // fill to capacity, then overflow
        for (k = 1; k < 16; k++)
            directed_action(ACT_APPEND, 4'd0, (k == 15) ? 8'hff : 8'(k * 17));
        directed_action(ACT_APPEND, 4'd0, 8'h01);
        directed_action(ACT_INSERT, 4'd3, 8'h02);
        directed_action(ACT_READ, 4'd15, 8'h00);
        directed_action(ACT_OVERWRITE, 4'd15, 8'h80);
        directed_action(ACT_SEARCH, 4'd0, 8'h80);
        directed_action(ACT_SEARCH, 4'd0, 8'h7e);
        directed_action(ACT_REMOVE, 4'd15, 8'h00);
        directed_action(ACT_REMOVE, 4'd0, 8'h00);
        directed_action(ACT_INSERT, 4'd14, 8'h33);

        phase = PH_GROW;
        while (n_random < RANDOM_ITEMS) begin
            if ((n_random % 40) == 0)
                phase = phase_t'($urandom_range(0, 2));
            if ((n_random % 150) == 0)
                calm = ($urandom_range(0, 3) == 0);
            act = pick_action(phase);
            k = $urandom_range(0, 9);
            pos = (k == 0) ? 4'd0 : (k == 1) ? 4'd15 : 4'($urandom_range(0, 15));
            val = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 7))
                                              : 8'($urandom_range(0, 255));
            send_action(act, pos, val);
            if (act != ACT_RSVD_LO && act != ACT_RSVD_HI)
                n_random++;
        end
        s_tvalid = 1'b0;
        calm = 1'b0;

        while (pending != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("sequential_char_list_tb: %0d directed and %0d random actions sent,",
                 n_directed, n_random);
        $display("  %0d result transfers checked under random gaps and output stalls",
                 checked);
        if (errors == 0)
            $display("sequential_char_list_tb: done, clean");
        else
            $display("sequential_char_list_tb: done, errors");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("sequential_char_list_tb: done, errors");
        $finish;
    end

endmodule
